// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ppm_pkg.sv -----
package ppm_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFLICT_BEGIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFLICT_END   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BRAKE_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_MISMATCH_LEVEL = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME      = 3'd4;

  localparam int CFG_DATA_BITS = 32;
  localparam int IN_TDATA_BITS = 80;
  localparam int OUT_TDATA_BITS = 8;

  typedef struct packed {
    logic [15:0] conflict_begin_level;
    logic [15:0] conflict_end_level;
    logic [15:0] brake_level;
    logic [15:0] mismatch_level;
    logic [31:0] hold_time;
  } cfg_t;

  typedef struct packed {
    logic [31:0] sample_time;
    logic [15:0] brake_raw;
    logic [15:0] throttle_b;
    logic [15:0] throttle_a;
  } sample_t;

  typedef struct packed {
    logic mismatch_seen;
    logic implausible_fault;
    logic brake_conflict;
  } result_t;

endpackage

// ----- rtl/ppm_cfg_regs.sv -----
module ppm_cfg_regs
  import ppm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  // Register file; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CONFLICT_BEGIN: cfg.conflict_begin_level <= cfg_data[15:0];
        REG_CONFLICT_END:   cfg.conflict_end_level   <= cfg_data[15:0];
        REG_BRAKE_LEVEL:    cfg.brake_level          <= cfg_data[15:0];
        REG_MISMATCH_LEVEL: cfg.mismatch_level       <= cfg_data[15:0];
        REG_HOLD_TIME:      cfg.hold_time            <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/ppm_core.sv -----
module ppm_core
  import ppm_pkg::*;
#(
  parameter int TIME_BITS = 32
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  cfg_t    cfg,
  input  sample_t sample,
  output result_t result
);

  logic                 mismatch_flag;
  logic                 fault_flag;
  logic                 conflict_flag;
  logic [TIME_BITS-1:0] mismatch_start;

  logic                 mismatch_flag_next;
  logic                 fault_flag_next;
  logic                 conflict_flag_next;
  logic [TIME_BITS-1:0] mismatch_start_next;

  logic [15:0]          lo;
  logic [15:0]          hi;
  logic                 mismatch;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] elapsed;

  // Sensor ordering and timestamp reduced to the timer width
  assign lo = (sample.throttle_a < sample.throttle_b) ? sample.throttle_a : sample.throttle_b;
  assign hi = (sample.throttle_a < sample.throttle_b) ? sample.throttle_b : sample.throttle_a;
  assign mismatch = (hi - lo) >= cfg.mismatch_level;
  assign now = TIME_BITS'({32'd0, sample.sample_time});
  assign elapsed = now - mismatch_start;

  always_comb begin
    // Brake conflict with hysteresis, held while the old fault stands
    conflict_flag_next = conflict_flag;
    if (!fault_flag) begin
      if (conflict_flag) begin
        conflict_flag_next = lo >= cfg.conflict_end_level;
      end else begin
        conflict_flag_next = (sample.brake_raw > cfg.brake_level) &&
                             (lo > cfg.conflict_begin_level);
      end
    end

    // Implausibility timer
    mismatch_flag_next  = mismatch_flag;
    fault_flag_next     = fault_flag;
    mismatch_start_next = mismatch_start;
    if (!mismatch) begin
      mismatch_flag_next = 1'b0;
      fault_flag_next    = 1'b0;
    end else if (!mismatch_flag) begin
      mismatch_flag_next  = 1'b1;
      mismatch_start_next = now;
    end else if (64'(elapsed) > 64'(cfg.hold_time)) begin
      fault_flag_next = 1'b1;
    end
  end

  assign result.brake_conflict    = conflict_flag_next;
  assign result.implausible_fault = fault_flag_next;
  assign result.mismatch_seen     = mismatch;

  always_ff @(posedge clk) begin
    if (rst) begin
      mismatch_flag  <= 1'b0;
      fault_flag     <= 1'b0;
      conflict_flag  <= 1'b0;
      mismatch_start <= '0;
    end else if (step) begin
      mismatch_flag  <= mismatch_flag_next;
      fault_flag     <= fault_flag_next;
      conflict_flag  <= conflict_flag_next;
      mismatch_start <= mismatch_start_next;
    end
  end

endmodule

// ----- rtl/pedal_plausibility_monitor_top.sv -----
// An accepted sample passes the input register, then the result register, to m_tdata.
// Throughput: one sample per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset (rst, synchronous, active high) clears the configuration, the fault, mismatch
// and conflict flags and both valid bits, not the data; configuration is always accepted.
module pedal_plausibility_monitor_top
  import ppm_pkg::*;
#(
  parameter int TIME_BITS = 32
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // throttle_a[15:0], throttle_b[31:16], brake_raw[47:32], sample_time[79:48]
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // brake_conflict[0], implausible_fault[1], mismatch_seen[2], zero[7:3]
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t    cfg;
  sample_t in_reg;
  logic    in_valid;
  result_t result;
  result_t out_reg;
  logic    advance;
  logic    step;

  assign cfg_ready = 1'b1;

  ppm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline handshake
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reg <= sample_t'(s_tdata);
    end
  end

  ppm_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .cfg    (cfg),
    .sample (in_reg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {5'd0, out_reg};

endmodule

// ----- rtl/ppm_checker.sv -----
`include "assert_macros.svh"

module ppm_checker
  import ppm_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_TDATA_BITS-1:0] m_tdata
);

  // A latched fault always comes with a mismatch on the same sample
  `ASSERT_CLK(a_fault_needs_mismatch, m_tvalid |-> !(m_tdata[1] && !m_tdata[2]), "fault without mismatch")

  // Pad bits of the result stay zero
  `ASSERT_CLK(a_pad_zero, m_tvalid |-> (m_tdata[7:3] == 5'd0), "nonzero pad bits")

  // An empty result register never blocks the input side
  `ASSERT_CLK(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

  // Stalled result holds
  `ASSERT_CLK(a_hold_stall, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

  // Nothing is presented right after reset
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

endmodule

bind pedal_plausibility_monitor_top ppm_checker u_ppm_checker (.*);
